FILE: src/tpk_pkg.sv
// Shared constants, types and state codes for the penalized spanning-forest block.
`timescale 1ns / 1ps
package tpk_pkg;

	localparam int ACTION_W     = 2;
	localparam int CITY_W       = 10;
	localparam int WEIGHT_W     = 16;
	localparam int COST_W       = 48;
	localparam int CITY_COUNT_W = 11;
	localparam int PENALTY_W    = 16;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 16;

	localparam int MAX_CITIES_DEF = 1024;
	localparam int MAX_EDGES_DEF  = 4096;
	localparam int MAX_RISKY_DEF  = 64;

	localparam logic [CITY_COUNT_W-1:0] CITY_COUNT_RST = 11'd1024;

	localparam logic [ACTION_W-1:0] ACT_RISKY = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_EDGE  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_RUN   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_CITY_COUNT   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_RISK_PENALTY = 1'b1;

	typedef struct packed {
		logic [CITY_W-1:0]          u;
		logic [CITY_W-1:0]          v;
		logic signed [WEIGHT_W-1:0] w;
	} edge_rec_t;

	typedef enum logic [4:0] {
		ST_INIT_CLR,
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_PRE_RD,
		ST_PRE_U,
		ST_PRE_V,
		ST_PRE_M,
		ST_PRE_P,
		ST_PRE_WR,
		ST_PAR_INIT,
		ST_SCAN_INIT,
		ST_SCAN,
		ST_PICK,
		ST_J_EDGE,
		ST_FU_RD,
		ST_FU_CK,
		ST_FV_RD,
		ST_FV_CK,
		ST_CHK_RD,
		ST_CHK_CT,
		ST_CHK_FRD,
		ST_CHK_FCK,
		ST_DECIDE,
		ST_FIN,
		ST_CLR_RD,
		ST_CLR_WR
	} state_t;

endpackage

FILE: src/tpk_ifs.sv
// Valid/ready channel interfaces: input items, results and register writes.
`timescale 1ns / 1ps
interface tpk_in_if;
	logic                                  valid;
	logic                                  ready;
	logic [tpk_pkg::ACTION_W-1:0]          action;
	logic [tpk_pkg::CITY_W-1:0]            risky_city;
	logic [tpk_pkg::CITY_W-1:0]            edge_u;
	logic [tpk_pkg::CITY_W-1:0]            edge_v;
	logic signed [tpk_pkg::WEIGHT_W-1:0]   edge_weight;
	modport source (output valid, action, risky_city, edge_u, edge_v, edge_weight,
		input ready);
	modport sink (input valid, action, risky_city, edge_u, edge_v, edge_weight,
		output ready);
endinterface

interface tpk_out_if;
	logic                                valid;
	logic                                ready;
	logic                                connected;
	logic signed [tpk_pkg::COST_W-1:0]   total_cost;
	modport source (output valid, connected, total_cost, input ready);
	modport sink (input valid, connected, total_cost, output ready);
endinterface

interface tpk_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [tpk_pkg::CFG_IDX_W-1:0]      index;
	logic [tpk_pkg::CFG_DATA_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: src/two_phase_penalized_kruskal_mst_top.sv
// Top level: item loading, two-phase penalized Kruskal run and result channel.
// Flow: edge beats are taken back to back while idle; a risky-city beat passes
// through ST_ADD_RD and ST_ADD_WR before the next beat, and after reset the block
// clears all MAX_CITIES per-city risk counters before taking the first beat
// (register writes are taken throughout). A run beat walks one sequencer over
// simple dual-port memories: it prices each stored edge in turn, sets up the
// parent table one city in use at a time, then for every edge picked in penalized
// weight order does a full scan of the edge table plus two root walks, and at the
// end of each phase checks each city in use with no risk count by its root walk.
// The scan per picked edge makes a run grow with the square of the edge count.
// The result sits in an output register; the stores are then cleared, each
// risky entry by a read and a write.
`timescale 1ns / 1ps
module two_phase_penalized_kruskal_mst_top #(
	parameter int MAX_CITIES = tpk_pkg::MAX_CITIES_DEF,
	parameter int MAX_EDGES  = tpk_pkg::MAX_EDGES_DEF,
	parameter int MAX_RISKY  = tpk_pkg::MAX_RISKY_DEF
) (
	input logic        clk,
	input logic        arst_n,
	tpk_in_if.sink     in_ch,
	tpk_out_if.source  out_ch,
	tpk_cfg_if.sink    cfg
);

	localparam int CIW  = $clog2(MAX_CITIES);
	localparam int CTW  = $clog2(MAX_CITIES + 1);
	localparam int EIW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ETW  = $clog2(MAX_EDGES + 1);
	localparam int RIW  = (MAX_RISKY > 1) ? $clog2(MAX_RISKY) : 1;
	localparam int RTW  = $clog2(MAX_RISKY + 1);
	localparam int PRW  = tpk_pkg::PENALTY_W + RTW;
	localparam int PW_W = PRW + 1 + 1;
	localparam int PME_W = PW_W + 2;

	tpk_pkg::state_t state_q, state_nx;

	logic [tpk_pkg::CITY_COUNT_W-1:0] city_count_q;
	logic [tpk_pkg::PENALTY_W-1:0]    penalty_q;

	logic [CTW-1:0] c_idx_q;
	logic [ETW-1:0] e_idx_q, e_total_q;
	logic [RTW-1:0] r_idx_q, r_total_q;
	logic [CIW-1:0] c_q, x_q, v_q, ra_q, root_q;
	tpk_pkg::edge_rec_t e_q;
	logic [RTW-1:0] mu_q, matches_q;
	logic [PRW-1:0] prod_q;
	logic phase_q, have_last_q, have_best_q, s1_v_q, found_q, joined_q;
	logic [ETW-1:0] j_s1, last_j_q, best_j_q;
	logic signed [PW_W-1:0] last_pw_q, best_pw_q;
	logic signed [tpk_pkg::COST_W-1:0] cost_q;
	logic out_v_q, out_conn_q;
	logic signed [tpk_pkg::COST_W-1:0] out_cost_q;

	// memories
	tpk_pkg::edge_rec_t edge_mem [MAX_EDGES];
	tpk_pkg::edge_rec_t edge_rd;
	logic [RTW-1:0]     cnt_mem [MAX_CITIES];
	logic [RTW-1:0]     cnt_rd;
	logic [CIW-1:0]     rl_mem [MAX_RISKY];
	logic [CIW-1:0]     rl_rd;
	logic [PME_W-1:0]   pm_mem [MAX_EDGES];
	logic [PME_W-1:0]   pm_rd;
	logic [CIW-1:0]     par_mem [MAX_CITIES];
	logic [CIW-1:0]     par_rd;

	logic               edge_we, cnt_we, rl_we, pm_we, par_we;
	logic [EIW-1:0]     edge_raddr;
	logic [CIW-1:0]     cnt_waddr, cnt_raddr, par_waddr, par_wdata;
	logic [RTW-1:0]     cnt_wdata;
	tpk_pkg::edge_rec_t edge_wdata;

	logic in_acc, out_acc, cfg_acc;
	logic [CTW-1:0] cities;
	logic risky_ok, edge_room, par_root, u_ok, v_ok, elig, cand, take;
	logic pm_elig, pm_safe;
	logic signed [PW_W-1:0] pm_pw, pw_sum;

	assign in_acc  = in_ch.valid & in_ch.ready;
	assign out_acc = out_ch.valid & out_ch.ready;
	assign cfg_acc = cfg.valid & cfg.ready;

	assign cities = ({21'd0, city_count_q} > 32'(MAX_CITIES)) ? CTW'(MAX_CITIES)
		: CTW'(city_count_q);
	assign risky_ok  = (r_total_q < RTW'(MAX_RISKY)) && (32'(in_ch.risky_city) < MAX_CITIES);
	assign edge_room = e_total_q < ETW'(MAX_EDGES);
	assign par_root  = par_rd == x_q;

	assign u_ok = 32'(e_q.u) < MAX_CITIES;
	assign v_ok = (e_q.v != e_q.u) && (32'(e_q.v) < MAX_CITIES);
	assign elig = (32'(e_q.u) < 32'(cities)) && (32'(e_q.v) < 32'(cities));
	assign pw_sum = $signed({{(PW_W - tpk_pkg::WEIGHT_W){e_q.w[tpk_pkg::WEIGHT_W-1]}}, e_q.w})
		+ $signed({2'b00, prod_q});

	assign pm_elig = pm_rd[PME_W-1];
	assign pm_safe = pm_rd[PME_W-2];
	assign pm_pw   = pm_rd[PW_W-1:0];

	assign cand = s1_v_q && pm_elig && (pm_safe == !phase_q) && (!have_last_q
		|| (pm_pw > last_pw_q) || ((pm_pw == last_pw_q) && (j_s1 > last_j_q)));
	assign take = cand && (!have_best_q || (pm_pw < best_pw_q));

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			tpk_pkg::ST_INIT_CLR: begin
				if (c_idx_q == CTW'(MAX_CITIES - 1)) state_nx = tpk_pkg::ST_IDLE;
			end
			tpk_pkg::ST_IDLE: begin
				if (in_acc && in_ch.action == tpk_pkg::ACT_RISKY && risky_ok)
					state_nx = tpk_pkg::ST_ADD_RD;
				else if (in_acc && in_ch.action == tpk_pkg::ACT_RUN)
					state_nx = tpk_pkg::ST_PRE_RD;
			end
			tpk_pkg::ST_ADD_RD:  state_nx = tpk_pkg::ST_ADD_WR;
			tpk_pkg::ST_ADD_WR:  state_nx = tpk_pkg::ST_IDLE;
			tpk_pkg::ST_PRE_RD: begin
				state_nx = (e_idx_q == e_total_q) ? tpk_pkg::ST_PAR_INIT : tpk_pkg::ST_PRE_U;
			end
			tpk_pkg::ST_PRE_U:   state_nx = tpk_pkg::ST_PRE_V;
			tpk_pkg::ST_PRE_V:   state_nx = tpk_pkg::ST_PRE_M;
			tpk_pkg::ST_PRE_M:   state_nx = tpk_pkg::ST_PRE_P;
			tpk_pkg::ST_PRE_P:   state_nx = tpk_pkg::ST_PRE_WR;
			tpk_pkg::ST_PRE_WR:  state_nx = tpk_pkg::ST_PRE_RD;
			tpk_pkg::ST_PAR_INIT: begin
				if (c_idx_q == cities) state_nx = tpk_pkg::ST_SCAN_INIT;
			end
			tpk_pkg::ST_SCAN_INIT: state_nx = tpk_pkg::ST_SCAN;
			tpk_pkg::ST_SCAN: begin
				if (e_idx_q == e_total_q) state_nx = tpk_pkg::ST_PICK;
			end
			tpk_pkg::ST_PICK: begin
				state_nx = have_best_q ? tpk_pkg::ST_J_EDGE : tpk_pkg::ST_CHK_RD;
			end
			tpk_pkg::ST_J_EDGE:  state_nx = tpk_pkg::ST_FU_RD;
			tpk_pkg::ST_FU_RD:   state_nx = tpk_pkg::ST_FU_CK;
			tpk_pkg::ST_FU_CK: begin
				state_nx = par_root ? tpk_pkg::ST_FV_RD : tpk_pkg::ST_FU_RD;
			end
			tpk_pkg::ST_FV_RD:   state_nx = tpk_pkg::ST_FV_CK;
			tpk_pkg::ST_FV_CK: begin
				state_nx = par_root ? tpk_pkg::ST_SCAN_INIT : tpk_pkg::ST_FV_RD;
			end
			tpk_pkg::ST_CHK_RD: begin
				state_nx = (c_idx_q == cities) ? tpk_pkg::ST_DECIDE : tpk_pkg::ST_CHK_CT;
			end
			tpk_pkg::ST_CHK_CT: begin
				state_nx = (cnt_rd != '0) ? tpk_pkg::ST_CHK_RD : tpk_pkg::ST_CHK_FRD;
			end
			tpk_pkg::ST_CHK_FRD: state_nx = tpk_pkg::ST_CHK_FCK;
			tpk_pkg::ST_CHK_FCK: begin
				if (!par_root) state_nx = tpk_pkg::ST_CHK_FRD;
				else if (found_q && x_q != root_q) state_nx = tpk_pkg::ST_DECIDE;
				else state_nx = tpk_pkg::ST_CHK_RD;
			end
			tpk_pkg::ST_DECIDE: begin
				state_nx = (joined_q || phase_q) ? tpk_pkg::ST_FIN : tpk_pkg::ST_SCAN_INIT;
			end
			tpk_pkg::ST_FIN: begin
				if (!out_v_q) state_nx = tpk_pkg::ST_CLR_RD;
			end
			tpk_pkg::ST_CLR_RD: begin
				state_nx = (r_idx_q == r_total_q) ? tpk_pkg::ST_IDLE : tpk_pkg::ST_CLR_WR;
			end
			tpk_pkg::ST_CLR_WR:  state_nx = tpk_pkg::ST_CLR_RD;
			default:             state_nx = tpk_pkg::ST_IDLE;
		endcase
	end

	// memory controls and handshakes
	always_comb begin
		in_ch.ready = state_q == tpk_pkg::ST_IDLE;
		cfg.ready   = 1'b1;
		edge_we     = in_acc && in_ch.action == tpk_pkg::ACT_EDGE && edge_room;
		edge_wdata.u = in_ch.edge_u;
		edge_wdata.v = in_ch.edge_v;
		edge_wdata.w = in_ch.edge_weight;
		edge_raddr  = (state_q == tpk_pkg::ST_PICK) ? best_j_q[EIW-1:0] : e_idx_q[EIW-1:0];
		cnt_we      = 1'b0;
		cnt_waddr   = c_idx_q[CIW-1:0];
		cnt_wdata   = '0;
		cnt_raddr   = c_idx_q[CIW-1:0];
		rl_we       = state_q == tpk_pkg::ST_ADD_WR;
		pm_we       = state_q == tpk_pkg::ST_PRE_WR;
		par_we      = 1'b0;
		par_waddr   = c_idx_q[CIW-1:0];
		par_wdata   = c_idx_q[CIW-1:0];
		unique case (state_q)
			tpk_pkg::ST_INIT_CLR: cnt_we = 1'b1;
			tpk_pkg::ST_ADD_RD:   cnt_raddr = c_q;
			tpk_pkg::ST_ADD_WR: begin
				cnt_we    = 1'b1;
				cnt_waddr = c_q;
				cnt_wdata = cnt_rd + RTW'(1);
			end
			tpk_pkg::ST_PRE_U:    cnt_raddr = CIW'(edge_rd.u);
			tpk_pkg::ST_PRE_V:    cnt_raddr = CIW'(e_q.v);
			tpk_pkg::ST_PAR_INIT: par_we = c_idx_q != cities;
			tpk_pkg::ST_FV_CK: begin
				par_we    = par_root && (ra_q != x_q);
				par_waddr = ra_q;
				par_wdata = x_q;
			end
			tpk_pkg::ST_CLR_WR: begin
				cnt_we    = 1'b1;
				cnt_waddr = rl_rd;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (edge_we) edge_mem[e_total_q[EIW-1:0]] <= edge_wdata;
		edge_rd <= edge_mem[edge_raddr];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
		cnt_rd <= cnt_mem[cnt_raddr];
	end

	always_ff @(posedge clk) begin
		if (rl_we) rl_mem[r_total_q[RIW-1:0]] <= c_q;
		rl_rd <= rl_mem[r_idx_q[RIW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (pm_we) pm_mem[e_idx_q[EIW-1:0]] <= {elig, matches_q == '0, pw_sum};
		pm_rd <= pm_mem[e_idx_q[EIW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (par_we) par_mem[par_waddr] <= par_wdata;
		par_rd <= par_mem[x_q];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == tpk_pkg::ST_IDLE) c_q <= CIW'(in_ch.risky_city);
		if (state_q == tpk_pkg::ST_PRE_U) e_q <= edge_rd;
		if (state_q == tpk_pkg::ST_PRE_V) mu_q <= u_ok ? cnt_rd : '0;
		if (state_q == tpk_pkg::ST_PRE_M) matches_q <= mu_q + (v_ok ? cnt_rd : RTW'(0));
		if (state_q == tpk_pkg::ST_PRE_P) prod_q <= penalty_q * matches_q;
		if (state_q == tpk_pkg::ST_SCAN) j_s1 <= e_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tpk_pkg::ST_INIT_CLR;
			city_count_q <= tpk_pkg::CITY_COUNT_RST;
			penalty_q    <= '0;
			c_idx_q      <= '0;
			e_idx_q      <= '0;
			e_total_q    <= '0;
			r_idx_q      <= '0;
			r_total_q    <= '0;
			x_q          <= '0;
			v_q          <= '0;
			ra_q         <= '0;
			root_q       <= '0;
			phase_q      <= 1'b0;
			have_last_q  <= 1'b0;
			have_best_q  <= 1'b0;
			s1_v_q       <= 1'b0;
			found_q      <= 1'b0;
			joined_q     <= 1'b0;
			last_j_q     <= '0;
			best_j_q     <= '0;
			last_pw_q    <= '0;
			best_pw_q    <= '0;
			cost_q       <= '0;
			out_v_q      <= 1'b0;
			out_conn_q   <= 1'b0;
			out_cost_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (cfg_acc) begin
				unique case (cfg.index)
					tpk_pkg::CFG_CITY_COUNT:   city_count_q <= cfg.data[tpk_pkg::CITY_COUNT_W-1:0];
					tpk_pkg::CFG_RISK_PENALTY: penalty_q <= cfg.data[tpk_pkg::PENALTY_W-1:0];
					default: begin
					end
				endcase
			end
			if (out_acc) out_v_q <= 1'b0;
			unique case (state_q)
				tpk_pkg::ST_INIT_CLR: c_idx_q <= c_idx_q + CTW'(1);
				tpk_pkg::ST_IDLE: begin
					if (edge_we) e_total_q <= e_total_q + ETW'(1);
					if (in_acc && in_ch.action == tpk_pkg::ACT_RUN) begin
						e_idx_q <= '0;
						cost_q  <= '0;
					end
				end
				tpk_pkg::ST_ADD_WR: r_total_q <= r_total_q + RTW'(1);
				tpk_pkg::ST_PRE_RD: begin
					if (e_idx_q == e_total_q) c_idx_q <= '0;
				end
				tpk_pkg::ST_PRE_WR: e_idx_q <= e_idx_q + ETW'(1);
				tpk_pkg::ST_PAR_INIT: begin
					if (c_idx_q != cities) begin
						c_idx_q <= c_idx_q + CTW'(1);
					end else begin
						phase_q     <= 1'b0;
						have_last_q <= 1'b0;
					end
				end
				tpk_pkg::ST_SCAN_INIT: begin
					e_idx_q     <= '0;
					s1_v_q      <= 1'b0;
					have_best_q <= 1'b0;
				end
				tpk_pkg::ST_SCAN: begin
					s1_v_q <= e_idx_q != e_total_q;
					if (e_idx_q != e_total_q) e_idx_q <= e_idx_q + ETW'(1);
					if (take) begin
						have_best_q <= 1'b1;
						best_pw_q   <= pm_pw;
						best_j_q    <= j_s1;
					end
				end
				tpk_pkg::ST_PICK: begin
					if (have_best_q) begin
						last_pw_q   <= best_pw_q;
						last_j_q    <= best_j_q;
						have_last_q <= 1'b1;
					end else begin
						c_idx_q <= '0;
						found_q <= 1'b0;
					end
				end
				tpk_pkg::ST_J_EDGE: begin
					x_q <= CIW'(edge_rd.u);
					v_q <= CIW'(edge_rd.v);
				end
				tpk_pkg::ST_FU_CK: begin
					if (par_root) begin
						ra_q <= x_q;
						x_q  <= v_q;
					end else begin
						x_q <= par_rd;
					end
				end
				tpk_pkg::ST_FV_CK: begin
					if (!par_root) x_q <= par_rd;
					else if (ra_q != x_q) cost_q <= cost_q + tpk_pkg::COST_W'(best_pw_q);
				end
				tpk_pkg::ST_CHK_RD: begin
					if (c_idx_q == cities) joined_q <= 1'b1;
				end
				tpk_pkg::ST_CHK_CT: begin
					if (cnt_rd != '0) c_idx_q <= c_idx_q + CTW'(1);
					else x_q <= c_idx_q[CIW-1:0];
				end
				tpk_pkg::ST_CHK_FCK: begin
					if (!par_root) begin
						x_q <= par_rd;
					end else if (!found_q) begin
						found_q <= 1'b1;
						root_q  <= x_q;
						c_idx_q <= c_idx_q + CTW'(1);
					end else if (x_q == root_q) begin
						c_idx_q <= c_idx_q + CTW'(1);
					end else begin
						joined_q <= 1'b0;
					end
				end
				tpk_pkg::ST_DECIDE: begin
					if (!(joined_q || phase_q)) begin
						phase_q     <= 1'b1;
						have_last_q <= 1'b0;
					end
				end
				tpk_pkg::ST_FIN: begin
					if (!out_v_q) begin
						out_v_q    <= 1'b1;
						out_conn_q <= joined_q;
						out_cost_q <= joined_q ? cost_q : '0;
						r_idx_q    <= '0;
					end
				end
				tpk_pkg::ST_CLR_RD: begin
					if (r_idx_q == r_total_q) begin
						r_total_q <= '0;
						e_total_q <= '0;
					end
				end
				tpk_pkg::ST_CLR_WR: r_idx_q <= r_idx_q + RTW'(1);
				default: begin
				end
			endcase
		end
	end

	assign out_ch.valid      = out_v_q;
	assign out_ch.connected  = out_conn_q;
	assign out_ch.total_cost = out_cost_q;

	a_risky_bound: assert property (@(posedge clk) disable iff (!arst_n)
		r_total_q <= RTW'(MAX_RISKY))
		else $error("risky entry count over capacity");

	a_edge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		e_total_q <= ETW'(MAX_EDGES))
		else $error("edge count over capacity");

	a_unconnected_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_conn_q) |-> (out_cost_q == '0))
		else $error("cost reported for an unconnected result");

	a_stores_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tpk_pkg::ST_IDLE && $past(state_q) == tpk_pkg::ST_CLR_RD)
		|-> (e_total_q == '0 && r_total_q == '0))
		else $error("stores not cleared after run");

endmodule
